// File: rtl/core/clnbw_pkg.sv
// Shared constants, codes and types for the character display nibble writer.
package clnbw_pkg;

    // Request kinds carried in the slave-side tuser.
    localparam logic [1:0] CMD_CHAR   = 2'd0;
    localparam logic [1:0] CMD_INSTR  = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;
    localparam logic [1:0] CMD_DEC    = 2'd3;

    // Decimal conversion sizing: a 32-bit value has at most ten digits.
    localparam int VALUE_W    = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int MAX_DIGITS = 10;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);

    // Display byte constants.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] SET_DDRAM   = 8'h80;
    localparam logic [7:0] ROW1_OFFSET = 8'h40;

    // One display byte handed to the nibble transmitter.
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       rs;
        logic       last;
    } t_tx_req;

    // Digit stream offered by the decimal converter.
    typedef struct packed {
        logic       rdy;
        logic [3:0] digit;
        logic       last;
        logic       single;
    } t_dig_stat;

endpackage

// File: rtl/core/clnbw_dec_conv.sv
// Bit-serial binary to decimal converter that offers the digits most significant first.
module clnbw_dec_conv
    import clnbw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_next,
    output t_dig_stat          o_stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_STRIP,
        ST_CLAMP,
        ST_OUT
    } t_state;

    t_state               r_state;
    logic [VALUE_W-1:0]   r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic [NDIG_W-1:0]    r_ndig;
    logic                 r_single;
    logic [BCD_W-1:0]     n_adj;
    logic [3:0]           top_digit;

    // Add-three correction on every digit before the next doubling.
    always_comb begin
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ndig   <= '0;
            r_single <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_bin   <= i_value;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                    r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                        r_ndig  <= NDIG_W'(DEC_DIGITS);
                        r_state <= ST_STRIP;
                    end
                end
                ST_STRIP: begin
                    // Drop leading zeros, but always keep one digit.
                    if (top_digit == 4'd0 && r_ndig > NDIG_W'(1)) begin
                        r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - 1'b1;
                    end else begin
                        r_single <= (r_ndig == NDIG_W'(1));
                        r_state  <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    // Keep only the lowest digits when the number is too long.
                    if (int'(r_ndig) > MAX_DIGITS) begin
                        r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - 1'b1;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_next) begin
                        r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - 1'b1;
                        if (r_ndig == NDIG_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_stat.rdy    = (r_state == ST_OUT);
        o_stat.digit  = top_digit;
        o_stat.last   = (r_ndig == NDIG_W'(1));
        o_stat.single = r_single;
    end

endmodule

// File: rtl/core/clnbw_nibble_tx.sv
// Splits one display byte into four expander bytes and holds them on the master side.
module clnbw_nibble_tx
    import clnbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tx_req    i_req,
    input  logic       i_backlight,
    output logic       o_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       r_busy;
    logic [1:0] r_phase;
    logic [7:0] r_data;
    logic       r_rs;
    logic       r_last;
    logic [3:0] nibble;

    // A new byte may be loaded in the cycle the final enable-low byte leaves.
    assign o_ready = !r_busy || (r_phase == 2'd3 && m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (i_req.vld && o_ready) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
            r_data  <= i_req.data;
            r_rs    <= i_req.rs;
            r_last  <= i_req.last;
        end else if (r_busy && m_tready) begin
            if (r_phase == 2'd3) begin
                r_busy <= 1'b0;
            end
            r_phase <= r_phase + 1'b1;
        end
    end

    assign nibble   = r_phase[1] ? r_data[3:0] : r_data[7:4];
    assign m_tvalid = r_busy;
    assign m_tdata  = {nibble, i_backlight, ~r_phase[0], 1'b0, r_rs};
    assign m_tlast  = r_last && (r_phase == 2'd3);

endmodule

// File: rtl/core/char_lcd_nibble_byte_writer_top.sv
// Top level of the character display writer for a 4-bit display behind an I/O expander.
//
// Requests arrive on the slave stream: tuser carries the request kind (write character,
// write instruction, set cursor, write decimal value) and tdata carries the value, row
// and column. Each resulting display byte leaves on the master stream as four expander
// bytes: high nibble with enable set, then clear, then the low nibble the same way.
// tlast marks the final expander byte of a request. A cursor request with a row above
// one or a column above fifteen is consumed and produces no transaction at all.
//
// One request is handled at a time; s_tready is high only while the block is idle.
// A character, instruction or cursor request is registered in the sequencer and then
// in the transmitter before its first byte shows, and takes four output transactions.
// A decimal request first runs the bit-serial converter: one doubling per value bit,
// then the leading zeros are stripped and the digit count is clamped before the first
// byte appears; after that every digit costs four transactions and the digits stream
// with no gap while the receiver keeps m_tready high. A stalled receiver holds the byte.
//
// Synchronous active-low reset empties the pipeline and sets backlight on. The
// backlight register is written through i_cfg_we and should change only while idle.
module char_lcd_nibble_byte_writer_top
    import clnbw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], row [33:32], column [38:34], zero [39]
    input  logic [1:0]  s_tuser,   // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // rs [0], zero [1], enable [2], backlight [3], nibble [7:4]
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ONE,
        ST_DEC
    } t_state;

    t_state    r_state;
    logic      r_backlight;
    logic [7:0] r_byte;
    logic      r_rs;
    logic      r_pfx;
    logic      in_fire;
    logic      tx_ready;
    logic      dig_next;
    t_tx_req   tx_req;
    t_dig_stat dig;

    logic [VALUE_W-1:0] in_value;
    logic [1:0]         in_row;
    logic [4:0]         in_col;
    logic [1:0]         in_cmd;

    assign in_value = s_tdata[31:0];
    assign in_row   = s_tdata[33:32];
    assign in_col   = s_tdata[38:34];
    assign in_cmd   = s_tuser;

    assign s_tready = (r_state == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Backlight configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
        end else if (i_cfg_we) begin
            r_backlight <= i_cfg_wdata;
        end
    end

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pfx   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_pfx <= 1'b0;
                        unique case (in_cmd)
                            CMD_CHAR: begin
                                r_byte  <= in_value[7:0];
                                r_rs    <= 1'b1;
                                r_state <= ST_ONE;
                            end
                            CMD_INSTR: begin
                                r_byte  <= in_value[7:0];
                                r_rs    <= 1'b0;
                                r_state <= ST_ONE;
                            end
                            CMD_CURSOR: begin
                                if (in_row <= 2'd1 && in_col <= 5'd15) begin
                                    r_byte  <= SET_DDRAM | (in_row[0] ? ROW1_OFFSET : 8'h00)
                                               | {4'd0, in_col[3:0]};
                                    r_rs    <= 1'b0;
                                    r_state <= ST_ONE;
                                end
                            end
                            CMD_DEC: begin
                                r_state <= ST_DEC;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_ONE: begin
                    if (tx_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DEC: begin
                    if (dig.rdy && tx_ready) begin
                        if (dig.single && !r_pfx) begin
                            r_pfx <= 1'b1;
                        end else if (dig.last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Byte offered to the transmitter; a lone digit is preceded by an extra '0'.
    always_comb begin
        tx_req   = '0;
        dig_next = 1'b0;
        if (r_state == ST_ONE) begin
            tx_req.vld  = 1'b1;
            tx_req.data = r_byte;
            tx_req.rs   = r_rs;
            tx_req.last = 1'b1;
        end else if (r_state == ST_DEC && dig.rdy) begin
            tx_req.vld = 1'b1;
            tx_req.rs  = 1'b1;
            if (dig.single && !r_pfx) begin
                tx_req.data = ASCII_ZERO;
                tx_req.last = 1'b0;
            end else begin
                tx_req.data = ASCII_ZERO | {4'd0, dig.digit};
                tx_req.last = dig.last;
                dig_next    = tx_ready;
            end
        end
    end

    clnbw_dec_conv u_dec_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && in_cmd == CMD_DEC),
        .i_value (in_value),
        .i_next  (dig_next),
        .o_stat  (dig)
    );

    clnbw_nibble_tx u_nibble_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (tx_req),
        .i_backlight (r_backlight),
        .o_ready     (tx_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
